// File: design/pthc_pkg.sv
`default_nettype none
// ============================================================================
// pthc_pkg: shared types, constants and microcode for the compensation unit
// Q24 fixed point constants, the sequencer program and the control types
// exchanged between the sequencer and the serial arithmetic unit.
// ============================================================================
package pthc_pkg;

    localparam int unsigned FRAC_W    = 24;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned DIVN_W    = WORD_W + FRAC_W;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned PC_W      = 7;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(WORD_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIVN_W - 1);

    // input opcodes
    localparam logic [1:0] OPC_TEMP  = 2'd0;
    localparam logic [1:0] OPC_PRESS = 2'd1;
    localparam logic [1:0] OPC_HUM   = 2'd2;
    localparam logic [1:0] OPC_NONE  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_TEMP       = 3'd0;
    localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
    localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
    localparam logic [2:0] REG_PRESS_LAST = 3'd3;
    localparam logic [2:0] REG_HUM        = 3'd4;

    // output scaling shifts
    localparam logic [4:0] SH_TP = 5'd16;
    localparam logic [4:0] SH_H  = 5'd14;
    localparam logic [4:0] SH_FT = 5'd24;

    // program entry points
    localparam logic [PC_W-1:0] PC_TEMP  = 7'd0;
    localparam logic [PC_W-1:0] PC_PRESS = 7'd13;
    localparam logic [PC_W-1:0] PC_HUM   = 7'd49;
    localparam logic [PC_W-1:0] PC_NONE  = 7'd71;
    localparam logic [PC_W-1:0] PROG_LEN = 7'd72;

    localparam logic [WORD_W-1:0] K_1        = 64'd1 << FRAC_W;
    localparam logic [WORD_W-1:0] K_2        = 64'd2 << FRAC_W;
    localparam logic [WORD_W-1:0] K_4        = 64'd4 << FRAC_W;
    localparam logic [WORD_W-1:0] K_16       = 64'd16 << FRAC_W;
    localparam logic [WORD_W-1:0] K_64       = 64'd64 << FRAC_W;
    localparam logic [WORD_W-1:0] K_100      = 64'd100 << FRAC_W;
    localparam logic [WORD_W-1:0] K_1024     = 64'd1024 << FRAC_W;
    localparam logic [WORD_W-1:0] K_4096     = 64'd4096 << FRAC_W;
    localparam logic [WORD_W-1:0] K_5120     = 64'd5120 << FRAC_W;
    localparam logic [WORD_W-1:0] K_6250     = 64'd6250 << FRAC_W;
    localparam logic [WORD_W-1:0] K_8192     = 64'd8192 << FRAC_W;
    localparam logic [WORD_W-1:0] K_16384    = 64'd16384 << FRAC_W;
    localparam logic [WORD_W-1:0] K_32768    = 64'd32768 << FRAC_W;
    localparam logic [WORD_W-1:0] K_64000    = 64'd64000 << FRAC_W;
    localparam logic [WORD_W-1:0] K_65536    = 64'd65536 << FRAC_W;
    localparam logic [WORD_W-1:0] K_76800    = 64'd76800 << FRAC_W;
    localparam logic [WORD_W-1:0] K_131072   = 64'd131072 << FRAC_W;
    localparam logic [WORD_W-1:0] K_524288   = 64'd524288 << FRAC_W;
    localparam logic [WORD_W-1:0] K_1048576  = 64'd1048576 << FRAC_W;
    localparam logic [WORD_W-1:0] K_67108864 = 64'd67108864 << FRAC_W;
    localparam logic [WORD_W-1:0] K_2P31     = 64'd2147483648 << FRAC_W;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_JZ, OP_CLAMP, OP_FT, OP_OUT16, OP_OUT14
    } t_op;

    typedef enum logic [1:0] {D_R0, D_R1, D_R2, D_R3} t_dst;

    typedef enum logic [5:0] {
        S_R0, S_R1, S_R2, S_R3, S_RAW, S_RAWH, S_FT,
        S_T1, S_T2, S_T3,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_H1, S_H2, S_H3, S_H4, S_H5, S_H6,
        S_ZERO, S_K1, S_K2, S_K4, S_K16, S_K64, S_K1024, S_K4096, S_K5120,
        S_K6250, S_K8192, S_K16384, S_K32768, S_K64000, S_K65536, S_K76800,
        S_K131072, S_K524288, S_K1048576, S_K67108864, S_K2P31
    } t_src;

    typedef struct packed {
        t_op  op;
        t_dst dst;
        t_src a;
        t_src b;
    } t_instr;

    typedef struct packed {
        logic start;
        logic div;
    } t_su_req;

    typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_OUT} t_state;

    function automatic t_instr ins(t_op op, t_dst dst, t_src a, t_src b);
        t_instr r;
        r.op  = op;
        r.dst = dst;
        r.a   = a;
        r.b   = b;
        return r;
    endfunction

    function automatic t_instr prog_rom(logic [PC_W-1:0] pc);
        t_instr r;
        case (pc)
            // temperature
            7'd0:  r = ins(OP_DIV,   D_R0, S_RAW,  S_K16384);
            7'd1:  r = ins(OP_DIV,   D_R1, S_T1,   S_K1024);
            7'd2:  r = ins(OP_SUB,   D_R0, S_R0,   S_R1);
            7'd3:  r = ins(OP_DIV,   D_R1, S_RAW,  S_K131072);
            7'd4:  r = ins(OP_DIV,   D_R2, S_T1,   S_K8192);
            7'd5:  r = ins(OP_SUB,   D_R1, S_R1,   S_R2);
            7'd6:  r = ins(OP_MUL,   D_R0, S_R0,   S_T2);
            7'd7:  r = ins(OP_MUL,   D_R1, S_R1,   S_R1);
            7'd8:  r = ins(OP_MUL,   D_R1, S_R1,   S_T3);
            7'd9:  r = ins(OP_ADD,   D_R0, S_R0,   S_R1);
            7'd10: r = ins(OP_FT,    D_R0, S_R0,   S_ZERO);
            7'd11: r = ins(OP_DIV,   D_R0, S_R0,   S_K5120);
            7'd12: r = ins(OP_OUT16, D_R0, S_R0,   S_ZERO);
            // pressure
            7'd13: r = ins(OP_DIV,   D_R0, S_FT,   S_K2);
            7'd14: r = ins(OP_SUB,   D_R0, S_R0,   S_K64000);
            7'd15: r = ins(OP_MUL,   D_R1, S_R0,   S_R0);
            7'd16: r = ins(OP_DIV,   D_R1, S_R1,   S_K32768);
            7'd17: r = ins(OP_MUL,   D_R1, S_R1,   S_P6);
            7'd18: r = ins(OP_MUL,   D_R2, S_R0,   S_P5);
            7'd19: r = ins(OP_MUL,   D_R2, S_R2,   S_K2);
            7'd20: r = ins(OP_ADD,   D_R1, S_R1,   S_R2);
            7'd21: r = ins(OP_DIV,   D_R1, S_R1,   S_K4);
            7'd22: r = ins(OP_MUL,   D_R2, S_P4,   S_K65536);
            7'd23: r = ins(OP_ADD,   D_R1, S_R1,   S_R2);
            7'd24: r = ins(OP_MUL,   D_R2, S_P3,   S_R0);
            7'd25: r = ins(OP_DIV,   D_R2, S_R2,   S_K524288);
            7'd26: r = ins(OP_MUL,   D_R2, S_R2,   S_R0);
            7'd27: r = ins(OP_MUL,   D_R3, S_P2,   S_R0);
            7'd28: r = ins(OP_ADD,   D_R0, S_R2,   S_R3);
            7'd29: r = ins(OP_DIV,   D_R0, S_R0,   S_K524288);
            7'd30: r = ins(OP_DIV,   D_R0, S_R0,   S_K32768);
            7'd31: r = ins(OP_ADD,   D_R0, S_K1,   S_R0);
            7'd32: r = ins(OP_MUL,   D_R0, S_R0,   S_P1);
            7'd33: r = ins(OP_JZ,    D_R0, S_R0,   S_ZERO);
            7'd34: r = ins(OP_SUB,   D_R2, S_K1048576, S_RAW);
            7'd35: r = ins(OP_DIV,   D_R1, S_R1,   S_K4096);
            7'd36: r = ins(OP_SUB,   D_R2, S_R2,   S_R1);
            7'd37: r = ins(OP_MUL,   D_R2, S_R2,   S_K6250);
            7'd38: r = ins(OP_DIV,   D_R2, S_R2,   S_R0);
            7'd39: r = ins(OP_MUL,   D_R0, S_P9,   S_R2);
            7'd40: r = ins(OP_DIV,   D_R0, S_R0,   S_K2P31);
            7'd41: r = ins(OP_MUL,   D_R0, S_R0,   S_R2);
            7'd42: r = ins(OP_MUL,   D_R1, S_R2,   S_P8);
            7'd43: r = ins(OP_DIV,   D_R1, S_R1,   S_K32768);
            7'd44: r = ins(OP_ADD,   D_R0, S_R0,   S_R1);
            7'd45: r = ins(OP_ADD,   D_R0, S_R0,   S_P7);
            7'd46: r = ins(OP_DIV,   D_R0, S_R0,   S_K16);
            7'd47: r = ins(OP_ADD,   D_R0, S_R2,   S_R0);
            7'd48: r = ins(OP_OUT16, D_R0, S_R0,   S_ZERO);
            // humidity
            7'd49: r = ins(OP_SUB,   D_R0, S_FT,   S_K76800);
            7'd50: r = ins(OP_MUL,   D_R1, S_H3,   S_R0);
            7'd51: r = ins(OP_DIV,   D_R1, S_R1,   S_K67108864);
            7'd52: r = ins(OP_ADD,   D_R1, S_K1,   S_R1);
            7'd53: r = ins(OP_MUL,   D_R2, S_H6,   S_R0);
            7'd54: r = ins(OP_DIV,   D_R2, S_R2,   S_K67108864);
            7'd55: r = ins(OP_MUL,   D_R2, S_R2,   S_R1);
            7'd56: r = ins(OP_ADD,   D_R2, S_K1,   S_R2);
            7'd57: r = ins(OP_MUL,   D_R2, S_H2,   S_R2);
            7'd58: r = ins(OP_DIV,   D_R2, S_R2,   S_K65536);
            7'd59: r = ins(OP_MUL,   D_R1, S_H4,   S_K64);
            7'd60: r = ins(OP_MUL,   D_R3, S_H5,   S_R0);
            7'd61: r = ins(OP_DIV,   D_R3, S_R3,   S_K16384);
            7'd62: r = ins(OP_ADD,   D_R1, S_R1,   S_R3);
            7'd63: r = ins(OP_SUB,   D_R1, S_RAWH, S_R1);
            7'd64: r = ins(OP_MUL,   D_R1, S_R1,   S_R2);
            7'd65: r = ins(OP_MUL,   D_R3, S_H1,   S_R1);
            7'd66: r = ins(OP_DIV,   D_R3, S_R3,   S_K524288);
            7'd67: r = ins(OP_SUB,   D_R3, S_K1,   S_R3);
            7'd68: r = ins(OP_MUL,   D_R1, S_R1,   S_R3);
            7'd69: r = ins(OP_CLAMP, D_R1, S_R1,   S_ZERO);
            7'd70: r = ins(OP_OUT14, D_R0, S_R1,   S_ZERO);
            // unused opcode
            default: r = ins(OP_OUT16, D_R0, S_ZERO, S_ZERO);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/pthc_serial_unit.sv
`default_nettype none
// ============================================================================
// pthc_serial_unit: bit-serial Q24 multiplier and divider
// Sign-magnitude shift-add multiply (one bit a cycle) and restoring divide
// (one quotient bit a cycle), with saturation to the signed 64-bit range.
// ============================================================================
module pthc_serial_unit
    import pthc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_su_req           i_req,
    input  wire logic [WORD_W-1:0] i_a,
    input  wire logic [WORD_W-1:0] i_b,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_result
);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_div;
    logic                r_neg;
    logic                r_dz;
    logic [WORD_W-1:0]   r_ub;
    logic [WORD_W-1:0]   r_hi;
    logic [DIVN_W-1:0]   r_lo;

    logic [WORD_W-1:0]   s_ua;
    logic [WORD_W-1:0]   s_ub;
    logic [WORD_W:0]     s_msum;
    logic [WORD_W:0]     s_dt;
    logic [WORD_W:0]     s_ddiff;
    logic                s_dge;
    logic [WORD_W-1:0]   s_mag;
    logic [CNT_W-1:0]    s_last;

    function automatic logic [WORD_W-1:0] mag(logic [WORD_W-1:0] x);
        return x[WORD_W-1] ? (WORD_W'(0) - x) : x;
    endfunction

    function automatic logic [WORD_W-1:0] fx_make(logic neg, logic [WORD_W-1:0] m);
        logic [WORD_W-1:0] r;
        if (neg) begin
            r = m[WORD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : (WORD_W'(0) - m);
        end else begin
            r = m[WORD_W-1] ? {1'b0, {(WORD_W-1){1'b1}}} : m;
        end
        return r;
    endfunction

    assign s_ua    = mag(i_a);
    assign s_ub    = mag(i_b);
    assign s_msum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_ub} : {(WORD_W+1){1'b0}});
    assign s_dt    = {r_hi, r_lo[DIVN_W-1]};
    assign s_dge   = s_dt >= {1'b0, r_ub};
    assign s_ddiff = s_dt - {1'b0, r_ub};
    assign s_last  = r_div ? DIV_LAST : MUL_LAST;

    // product bits 87:24 or the quotient, saturated when wider than 64 bits
    always_comb begin
        if (r_div) begin
            s_mag = (r_lo[DIVN_W-1:WORD_W] != '0) ? '1 : r_lo[WORD_W-1:0];
        end else begin
            s_mag = (r_hi[WORD_W-1:FRAC_W] != '0) ? '1
                  : {r_hi[FRAC_W-1:0], r_lo[WORD_W-1:FRAC_W]};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_dz ? '0 : fx_make(r_neg, s_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == s_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.div;
            r_neg <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
            r_dz  <= i_req.div && (s_ub == '0);
            r_ub  <= s_ub;
            r_hi  <= '0;
            r_lo  <= i_req.div ? {s_ua, {FRAC_W{1'b0}}} : {{FRAC_W{1'b0}}, s_ua};
        end else if (r_busy) begin
            if (r_div) begin
                r_hi <= s_dge ? s_ddiff[WORD_W-1:0] : s_dt[WORD_W-1:0];
                r_lo <= {r_lo[DIVN_W-2:0], s_dge};
            end else begin
                r_hi <= s_msum[WORD_W:1];
                r_lo <= {r_lo[DIVN_W-1:WORD_W], s_msum[0], r_lo[WORD_W-1:1]};
            end
        end
    end

endmodule
`default_nettype wire

// File: design/pth_sensor_compensation_unit.sv
`default_nettype none
// ============================================================================
// pth_sensor_compensation_unit: temperature, pressure, humidity compensation
// Microcoded Q24 sequencer around one bit-serial multiply/divide unit.
// ============================================================================
// add, sub, clamp and store steps run in the sequencer, multiplies and divides in the
// serial unit (one bit a cycle).
// throughput: one item at a time; the next item is accepted when the result
// has moved to the output register, even if that register is still stalled.
// reset: synchronous active low, clears control, coefficients and fine temperature
module pth_sensor_compensation_unit
    import pthc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [19:0] i_raw_reading,
    // result item channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_value,
    output logic             o_zero_divisor,
    // coefficient register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    // sequencer state
    t_state              r_state;
    t_state              n_state;
    logic [PC_W-1:0]     r_pc;
    t_instr              r_instr;
    logic [19:0]         r_raw;

    // working registers and latched operands
    logic [WORD_W-1:0]   r_r0, r_r1, r_r2, r_r3;
    logic [WORD_W-1:0]   r_opa, r_opb;

    // stored fine temperature, integer degC * 5120
    logic [31:0]         r_ft;

    // coefficient registers
    logic [47:0]         r_temp_coefs;
    logic [63:0]         r_press_low;
    logic [63:0]         r_press_high;
    logic [15:0]         r_press_last;
    logic [63:0]         r_hum_coefs;

    // result staging and output register
    logic [31:0]         r_res_value;
    logic                r_res_zero;
    logic                r_ovalid;
    logic [31:0]         r_ovalue;
    logic                r_ozero;

    // control from the output decoder
    logic                s_accept;
    logic [PC_W-1:0]     s_entry_pc;
    logic                s_fetch;
    logic                s_wb;
    logic [WORD_W-1:0]   s_wb_data;
    logic                s_pc_inc;
    logic                s_ft_we;
    logic                s_res_we;
    logic [31:0]         s_res_value;
    logic                s_res_zero;
    logic                s_out_load;
    t_su_req             s_su_req;

    t_instr              s_rom;
    logic                s_su_done;
    logic [WORD_W-1:0]   s_su_result;
    logic                s_cfg_we;
    logic [2:0]          s_cfg_idx;

    // saturating 64-bit add / subtract
    function automatic logic [WORD_W-1:0] sat_sum(logic [WORD_W:0] s);
        logic [WORD_W-1:0] r;
        if (s[WORD_W] != s[WORD_W-1]) begin
            r = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            r = s[WORD_W-1:0];
        end
        return r;
    endfunction

    // truncate toward zero by sh bits, then saturate to 32 bits
    function automatic logic [31:0] fx_out(logic [WORD_W-1:0] x, logic [4:0] sh);
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] s;
        logic [31:0]       r;
        m = x[WORD_W-1] ? (WORD_W'(0) - x) : x;
        s = m >> sh;
        if (x[WORD_W-1]) begin
            r = (s > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - s[31:0]);
        end else begin
            r = (s > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : s[31:0];
        end
        return r;
    endfunction

    // humidity clamp to 0..100 %RH
    function automatic logic [WORD_W-1:0] clamp_h(logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        if (x[WORD_W-1]) begin
            r = '0;
        end else if (x > K_100) begin
            r = K_100;
        end else begin
            r = x;
        end
        return r;
    endfunction

    // operand source select: working regs, raw reading, coefficients, constants
    function automatic logic [WORD_W-1:0] src_val(t_src s);
        logic [WORD_W-1:0] v;
        case (s)
            S_R0:        v = r_r0;
            S_R1:        v = r_r1;
            S_R2:        v = r_r2;
            S_R3:        v = r_r3;
            S_RAW:       v = {20'd0, r_raw, 24'd0};
            S_RAWH:      v = {24'd0, r_raw[15:0], 24'd0};
            S_FT:        v = {{8{r_ft[31]}}, r_ft, 24'd0};
            S_T1:        v = {24'd0, r_temp_coefs[15:0], 24'd0};
            S_T2:        v = {{24{r_temp_coefs[31]}}, r_temp_coefs[31:16], 24'd0};
            S_T3:        v = {{24{r_temp_coefs[47]}}, r_temp_coefs[47:32], 24'd0};
            S_P1:        v = {24'd0, r_press_low[15:0], 24'd0};
            S_P2:        v = {{24{r_press_low[31]}}, r_press_low[31:16], 24'd0};
            S_P3:        v = {{24{r_press_low[47]}}, r_press_low[47:32], 24'd0};
            S_P4:        v = {{24{r_press_low[63]}}, r_press_low[63:48], 24'd0};
            S_P5:        v = {{24{r_press_high[15]}}, r_press_high[15:0], 24'd0};
            S_P6:        v = {{24{r_press_high[31]}}, r_press_high[31:16], 24'd0};
            S_P7:        v = {{24{r_press_high[47]}}, r_press_high[47:32], 24'd0};
            S_P8:        v = {{24{r_press_high[63]}}, r_press_high[63:48], 24'd0};
            S_P9:        v = {{24{r_press_last[15]}}, r_press_last, 24'd0};
            S_H1:        v = {32'd0, r_hum_coefs[7:0], 24'd0};
            S_H2:        v = {{24{r_hum_coefs[23]}}, r_hum_coefs[23:8], 24'd0};
            S_H3:        v = {32'd0, r_hum_coefs[31:24], 24'd0};
            S_H4:        v = {{28{r_hum_coefs[43]}}, r_hum_coefs[43:32], 24'd0};
            S_H5:        v = {{28{r_hum_coefs[55]}}, r_hum_coefs[55:44], 24'd0};
            S_H6:        v = {{32{r_hum_coefs[63]}}, r_hum_coefs[63:56], 24'd0};
            S_K1:        v = K_1;
            S_K2:        v = K_2;
            S_K4:        v = K_4;
            S_K16:       v = K_16;
            S_K64:       v = K_64;
            S_K1024:     v = K_1024;
            S_K4096:     v = K_4096;
            S_K5120:     v = K_5120;
            S_K6250:     v = K_6250;
            S_K8192:     v = K_8192;
            S_K16384:    v = K_16384;
            S_K32768:    v = K_32768;
            S_K64000:    v = K_64000;
            S_K65536:    v = K_65536;
            S_K76800:    v = K_76800;
            S_K131072:   v = K_131072;
            S_K524288:   v = K_524288;
            S_K1048576:  v = K_1048576;
            S_K67108864: v = K_67108864;
            S_K2P31:     v = K_2P31;
            default:     v = '0;
        endcase
        return v;
    endfunction

    assign s_rom = prog_rom(r_pc);

    // shared bit-serial multiply / divide
    pthc_serial_unit u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (s_su_req),
        .i_a      (r_opa),
        .i_b      (r_opb),
        .o_done   (s_su_done),
        .o_result (s_su_result)
    );

    // handshakes
    assign o_in_stall     = (r_state != ST_IDLE);
    assign s_accept       = i_in_valid && !o_in_stall;
    assign o_out_valid    = r_ovalid;
    assign o_value        = r_ovalue;
    assign o_zero_divisor = r_ozero;

    // register port
    assign pready    = 1'b1;
    assign s_cfg_idx = paddr[5:3];
    assign s_cfg_we  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (s_cfg_idx)
            REG_TEMP:       prdata = {16'd0, r_temp_coefs};
            REG_PRESS_LOW:  prdata = r_press_low;
            REG_PRESS_HIGH: prdata = r_press_high;
            REG_PRESS_LAST: prdata = {48'd0, r_press_last};
            REG_HUM:        prdata = r_hum_coefs;
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        unique case (i_opcode)
            OPC_TEMP:  s_entry_pc = PC_TEMP;
            OPC_PRESS: s_entry_pc = PC_PRESS;
            OPC_HUM:   s_entry_pc = PC_HUM;
            OPC_NONE:  s_entry_pc = PC_NONE;
            default:   s_entry_pc = PC_NONE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) n_state = ST_FETCH;
            end
            ST_FETCH: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                case (r_instr.op)
                    OP_MUL, OP_DIV:     n_state = ST_WAIT;
                    OP_OUT16, OP_OUT14: n_state = ST_OUT;
                    OP_JZ:              n_state = (r_opa == '0) ? ST_OUT : ST_FETCH;
                    default:            n_state = ST_FETCH;
                endcase
            end
            ST_WAIT: begin
                if (s_su_done) n_state = ST_FETCH;
            end
            ST_OUT: begin
                if (!r_ovalid || !i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_fetch     = 1'b0;
        s_wb        = 1'b0;
        s_wb_data   = s_su_result;
        s_pc_inc    = 1'b0;
        s_ft_we     = 1'b0;
        s_res_we    = 1'b0;
        s_res_value = '0;
        s_res_zero  = 1'b0;
        s_out_load  = 1'b0;
        s_su_req    = '0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_FETCH: begin
                s_fetch = 1'b1;
            end
            ST_EXEC: begin
                case (r_instr.op)
                    OP_ADD: begin
                        s_wb      = 1'b1;
                        s_wb_data = sat_sum({r_opa[WORD_W-1], r_opa}
                                            + {r_opb[WORD_W-1], r_opb});
                        s_pc_inc  = 1'b1;
                    end
                    OP_SUB: begin
                        s_wb      = 1'b1;
                        s_wb_data = sat_sum({r_opa[WORD_W-1], r_opa}
                                            - {r_opb[WORD_W-1], r_opb});
                        s_pc_inc  = 1'b1;
                    end
                    OP_MUL: begin
                        s_su_req.start = 1'b1;
                    end
                    OP_DIV: begin
                        s_su_req.start = 1'b1;
                        s_su_req.div   = 1'b1;
                    end
                    OP_JZ: begin
                        // zero pressure divisor ends the item with the flag set
                        if (r_opa == '0) begin
                            s_res_we   = 1'b1;
                            s_res_zero = 1'b1;
                        end else begin
                            s_pc_inc = 1'b1;
                        end
                    end
                    OP_CLAMP: begin
                        s_wb      = 1'b1;
                        s_wb_data = clamp_h(r_opa);
                        s_pc_inc  = 1'b1;
                    end
                    OP_FT: begin
                        s_ft_we  = 1'b1;
                        s_pc_inc = 1'b1;
                    end
                    OP_OUT16: begin
                        s_res_we    = 1'b1;
                        s_res_value = fx_out(r_opa, SH_TP);
                    end
                    OP_OUT14: begin
                        s_res_we    = 1'b1;
                        s_res_value = fx_out(r_opa, SH_H);
                    end
                    default: begin
                    end
                endcase
            end
            ST_WAIT: begin
                if (s_su_done) begin
                    s_wb     = 1'b1;
                    s_pc_inc = 1'b1;
                end
            end
            ST_OUT: begin
                s_out_load = !r_ovalid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ovalid     <= 1'b0;
            r_ft         <= '0;
            r_temp_coefs <= '0;
            r_press_low  <= '0;
            r_press_high <= '0;
            r_press_last <= '0;
            r_hum_coefs  <= '0;
        end else begin
            r_state <= n_state;
            if (s_out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (s_ft_we) r_ft <= fx_out(r_opa, SH_FT);
            if (s_cfg_we) begin
                case (s_cfg_idx)
                    REG_TEMP:       r_temp_coefs <= pwdata[47:0];
                    REG_PRESS_LOW:  r_press_low  <= pwdata;
                    REG_PRESS_HIGH: r_press_high <= pwdata;
                    REG_PRESS_LAST: r_press_last <= pwdata[15:0];
                    REG_HUM:        r_hum_coefs  <= pwdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_raw      <= i_raw_reading;
            r_pc       <= s_entry_pc;
            r_res_zero <= 1'b0;
        end else if (s_pc_inc) begin
            r_pc <= r_pc + PC_W'(1);
        end
        if (s_fetch) begin
            r_instr <= s_rom;
            r_opa   <= src_val(s_rom.a);
            r_opb   <= src_val(s_rom.b);
        end
        if (s_wb) begin
            case (r_instr.dst)
                D_R0:    r_r0 <= s_wb_data;
                D_R1:    r_r1 <= s_wb_data;
                D_R2:    r_r2 <= s_wb_data;
                D_R3:    r_r3 <= s_wb_data;
                default: r_r0 <= s_wb_data;
            endcase
        end
        if (s_res_we) begin
            r_res_value <= s_res_value;
            r_res_zero  <= s_res_zero;
        end
        if (s_out_load) begin
            r_ovalue <= r_res_value;
            r_ozero  <= r_res_zero;
        end
    end

`ifndef SYNTHESIS
    // a flagged pressure item always carries a zero value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_divisor) |-> (o_value == '0))
        else $error("zero divisor flag with nonzero value");

    // the serial unit only finishes while the sequencer waits for it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_su_done |-> (r_state == ST_WAIT))
        else $error("serial unit done outside wait state");

    // the program counter stays inside the program while an item runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH || r_state == ST_EXEC) |-> (r_pc < PROG_LEN))
        else $error("program counter out of range");

    // every serial start moves the sequencer into the wait state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_su_req.start |=> (r_state == ST_WAIT))
        else $error("serial start without wait");
`endif

endmodule
`default_nettype wire

// File: test/pth_sensor_compensation_unit_tb.sv
// ============================================================================
// pth_sensor_compensation_unit_tb: self-checking bench for the compensation unit
// Drives temperature, pressure, humidity and unused-opcode items with random
// idling on both channels. Each accepted item is run through a Q24 fixed point
// predictor, and the results are checked in order. Coefficients start at their
// reset value of zero and are loaded over the register port between later phases:
// typical, all-ones, max-positive and random sets.
// ============================================================================
module pth_sensor_compensation_unit_tb;
    import pthc_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd8000000;
    localparam longint Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint Q_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

    typedef struct {
        logic [1:0]  op;
        logic [19:0] raw;
    } t_reading;

    typedef struct {
        logic [31:0] value;
        logic        zero_div;
    } t_comp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_opcode = '0;
    logic [19:0] i_raw_reading = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_value;
    logic        o_zero_divisor;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    pth_sensor_compensation_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_opcode(i_opcode), .i_raw_reading(i_raw_reading),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_value(o_value), .o_zero_divisor(o_zero_divisor),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // pending readings, expected results and bench status
    t_reading reading_q[$];
    t_comp    comp_q[$];
    int       send_idle = 0;
    int       recv_idle = 0;
    int       fails = 0;
    int       n_checked = 0;
    int       n_zero_div = 0;
    longint   cycles = 0;

    // predictor copy of the coefficient registers and fine temperature
    logic [47:0] m_temp;
    logic [63:0] m_plow;
    logic [63:0] m_phigh;
    logic [15:0] m_plast;
    logic [63:0] m_hum;
    logic signed [31:0] m_fine;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // q24 arithmetic, saturating to 64 bits
    // ------------------------------------------------------------------
    function automatic longint q_int(longint n);
        return n * 64'sd16777216;
    endfunction

    function automatic logic [63:0] q_mag(longint x);
        return x < 0 ? 64'd0 - 64'(x) : 64'(x);
    endfunction

    // rebuild a signed value from a sign and a magnitude, saturating
    function automatic longint q_pack(logic neg, logic [63:0] m);
        if (neg)
            return m[63] ? Q_MIN : -longint'(m);
        return m[63] ? Q_MAX : longint'(m);
    endfunction

    function automatic longint q_add(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(Q_MAX)) return Q_MAX;
        if (s < 65'(Q_MIN)) return Q_MIN;
        return longint'(s);
    endfunction

    function automatic longint q_sub(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s > 65'(Q_MAX)) return Q_MAX;
        if (s < 65'(Q_MIN)) return Q_MIN;
        return longint'(s);
    endfunction

    // exact 128-bit product, truncated by 24 fractional bits
    function automatic longint q_mul(longint a, longint b);
        logic [127:0] p;
        p = 128'(q_mag(a)) * 128'(q_mag(b));
        if (p[127:88] != '0) return q_pack((a < 0) != (b < 0), '1);
        return q_pack((a < 0) != (b < 0), p[87:24]);
    endfunction

    // divide by zero gives 0 (the only variable divisor, on the pressure path, is guarded)
    function automatic longint q_div(longint a, longint b);
        logic [127:0] n;
        logic [127:0] q;
        if (b == 0) return 0;
        n = {40'd0, q_mag(a), 24'd0};
        q = n / 128'(q_mag(b));
        if (q[127:64] != '0) return q_pack((a < 0) != (b < 0), '1);
        return q_pack((a < 0) != (b < 0), q[63:0]);
    endfunction

    // truncate toward zero by sh bits and saturate to 32 bits
    function automatic logic [31:0] q_out(longint x, int sh);
        longint r;
        r = longint'(q_mag(x) >> sh);
        if (x < 0) r = -r;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // ------------------------------------------------------------------
    // compensation steps
    // ------------------------------------------------------------------
    function automatic logic [31:0] temp_comp(logic [19:0] raw);
        longint a, t1, t2, t3, d1, d2, s;
        a  = q_int(raw);
        t1 = q_int(m_temp[15:0]);
        t2 = q_int($signed(m_temp[31:16]));
        t3 = q_int($signed(m_temp[47:32]));
        d1 = q_sub(q_div(a, q_int(16384)), q_div(t1, q_int(1024)));
        d2 = q_sub(q_div(a, q_int(131072)), q_div(t1, q_int(8192)));
        s  = q_add(q_mul(d1, t2), q_mul(q_mul(d2, d2), t3));
        // fine temperature is kept as a truncated integer
        m_fine = q_out(s, 24);
        return q_out(q_div(s, q_int(5120)), 16);
    endfunction

    function automatic t_comp press_comp(logic [19:0] raw);
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
        t_comp r;
        p1 = q_int(m_plow[15:0]);
        p2 = q_int($signed(m_plow[31:16]));
        p3 = q_int($signed(m_plow[47:32]));
        p4 = q_int($signed(m_plow[63:48]));
        p5 = q_int($signed(m_phigh[15:0]));
        p6 = q_int($signed(m_phigh[31:16]));
        p7 = q_int($signed(m_phigh[47:32]));
        p8 = q_int($signed(m_phigh[63:48]));
        p9 = q_int($signed(m_plast));
        v1 = q_sub(q_div(q_int(m_fine), q_int(2)), q_int(64000));
        v2 = q_mul(q_div(q_mul(v1, v1), q_int(32768)), p6);
        v2 = q_add(v2, q_mul(q_mul(v1, p5), q_int(2)));
        v2 = q_add(q_div(v2, q_int(4)), q_mul(p4, q_int(65536)));
        v1 = q_add(q_mul(q_div(q_mul(p3, v1), q_int(524288)), v1), q_mul(p2, v1));
        v1 = q_div(v1, q_int(524288));
        v1 = q_mul(q_add(q_int(1), q_div(v1, q_int(32768))), p1);
        // zero divisor: value forced to 0 and flagged
        if (v1 == 0) begin
            r.value = '0;
            r.zero_div = 1'b1;
            return r;
        end
        p  = q_sub(q_int(1048576), q_int(raw));
        p  = q_div(q_mul(q_sub(p, q_div(v2, q_int(4096))), q_int(6250)), v1);
        v1 = q_mul(q_div(q_mul(p9, p), q_int(64'd2147483648)), p);
        v2 = q_div(q_mul(p, p8), q_int(32768));
        p  = q_add(p, q_div(q_add(q_add(v1, v2), p7), q_int(16)));
        r.value = q_out(p, 16);
        r.zero_div = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] hum_comp(logic [19:0] raw);
        longint h1, h2, h3, h4, h5, h6, h, ia, ib, g, o, vh;
        h1 = q_int(m_hum[7:0]);
        h2 = q_int($signed(m_hum[23:8]));
        h3 = q_int(m_hum[31:24]);
        h4 = q_int($signed(m_hum[43:32]));
        h5 = q_int($signed(m_hum[55:44]));
        h6 = q_int($signed(m_hum[63:56]));
        h  = q_sub(q_int(m_fine), q_int(76800));
        ia = q_add(q_int(1), q_div(q_mul(h3, h), q_int(67108864)));
        ib = q_add(q_int(1), q_mul(q_div(q_mul(h6, h), q_int(67108864)), ia));
        g  = q_div(q_mul(h2, ib), q_int(65536));
        o  = q_add(q_mul(h4, q_int(64)), q_div(q_mul(h5, h), q_int(16384)));
        // only the low 16 bits of the reading count for humidity
        vh = q_mul(q_sub(q_int(raw[15:0]), o), g);
        vh = q_mul(vh, q_sub(q_int(1), q_div(q_mul(h1, vh), q_int(524288))));
        // clamp to 0..100 %rh
        if (vh > q_int(100)) vh = q_int(100);
        else if (vh < 0) vh = 0;
        return q_out(vh, 14);
    endfunction

    function automatic t_comp compensate(t_reading it);
        t_comp r;
        r.value = '0;
        r.zero_div = 1'b0;
        case (it.op)
            OPC_TEMP:  r.value = temp_comp(it.raw);
            OPC_PRESS: r = press_comp(it.raw);
            OPC_HUM:   r.value = hum_comp(it.raw);
            default:   ;    // unused opcode: zero result, state untouched
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input driver: an item is taken on valid and not stall
    // ------------------------------------------------------------------
    t_reading drv_item;
    logic     drv_next = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            drv_next = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                drv_item.op = i_opcode;
                drv_item.raw = i_raw_reading;
                comp_q.push_back(compensate(drv_item));
                drv_next = 1'b0;
            end
            // load the next item unless this cycle is an idle one
            if (!drv_next && reading_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                drv_item = reading_q.pop_front();
                i_opcode <= drv_item.op;
                i_raw_reading <= drv_item.raw;
                drv_next = 1'b1;
            end
            i_in_valid <= drv_next;
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver stall
    // ------------------------------------------------------------------
    t_comp mon_exp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (comp_q.size() == 0) begin
                    $error("result with nothing expected: value %0d", $signed(o_value));
                    fails++;
                end else begin
                    mon_exp = comp_q.pop_front();
                    n_checked++;
                    if (mon_exp.zero_div) n_zero_div++;
                    if (o_value !== mon_exp.value) begin
                        $error("value: expected %0d, got %0d",
                               $signed(mon_exp.value), $signed(o_value));
                        fails++;
                    end
                    if (o_zero_divisor !== mon_exp.zero_div) begin
                        $error("zero_divisor: expected %0b, got %0b",
                               mon_exp.zero_div, o_zero_divisor);
                        fails++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(idx) << 3;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);    // register takes the data at this edge
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TEMP:       m_temp = val[47:0];
            REG_PRESS_LOW:  m_plow = val;
            REG_PRESS_HIGH: m_phigh = val;
            REG_PRESS_LAST: m_plast = val[15:0];
            REG_HUM:        m_hum = val;
            default:        ;
        endcase
    endtask

    task automatic load_coefs(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
                              logic [15:0] p9, logic [63:0] h);
        reg_write(REG_TEMP, 64'(t));
        reg_write(REG_PRESS_LOW, pl);
        reg_write(REG_PRESS_HIGH, ph);
        reg_write(REG_PRESS_LAST, 64'(p9));
        reg_write(REG_HUM, h);
    endtask

    task automatic queue_reading(logic [1:0] op, logic [19:0] raw);
        t_reading it;
        it.op = op;
        it.raw = raw;
        reading_q.push_back(it);
    endtask

    // hold off until every queued item has been taken and every result seen;
    // drv_next covers an item popped by the driver but not yet on the port
    task automatic wait_idle();
        while (reading_q.size() > 0 || i_in_valid || drv_next || comp_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // a temperature item followed by one to three pressure, humidity or, rarely, unused-opcode items
    task automatic queue_random(int n);
        int k;
        int pick;
        k = 0;
        while (k < n) begin
            queue_reading(OPC_TEMP, 20'($urandom));
            k++;
            repeat ($urandom_range(1, 3)) begin
                pick = $urandom_range(19);
                if (pick == 0)
                    queue_reading(OPC_NONE, 20'($urandom));
                else if (pick < 10)
                    queue_reading(OPC_PRESS, 20'($urandom));
                else
                    queue_reading(OPC_HUM, 20'($urandom));
                k++;
            end
        end
    endtask

    // typical factory calibration, packed
    localparam logic [47:0] T_TYP  = {16'hFC18, 16'h6743, 16'h6B70};
    localparam logic [63:0] PL_TYP = {16'h0B27, 16'h0BD0, 16'hD645, 16'h8E7D};
    localparam logic [63:0] PH_TYP = {16'hC6F8, 16'h3C8C, 16'hFFF9, 16'h008C};
    localparam logic [15:0] P9_TYP = 16'h1770;
    localparam logic [63:0] H_TYP  = {8'h1E, 12'h032, 12'h139, 8'h00, 16'h016A, 8'h4B};

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        m_temp = '0;
        m_plow = '0;
        m_phigh = '0;
        m_plast = '0;
        m_hum = '0;
        m_fine = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 14;
        recv_idle = 51;

        // coefficients at reset: pressure divisor is zero
        queue_reading(OPC_PRESS, 20'd0);
        queue_reading(OPC_TEMP, 20'hFFFFF);
        queue_reading(OPC_HUM, 20'hFFFFF);
        queue_reading(OPC_NONE, 20'hFFFFF);
        queue_reading(OPC_PRESS, 20'hFFFFF);
        wait_idle();

        // typical coefficients, field extremes and the unused opcode
        load_coefs(T_TYP, PL_TYP, PH_TYP, P9_TYP, H_TYP);
        queue_reading(OPC_HUM, 20'd30000);       // fine temperature still zero
        queue_reading(OPC_TEMP, 20'd519888);
        queue_reading(OPC_PRESS, 20'd415148);
        queue_reading(OPC_HUM, 20'd30000);
        queue_reading(OPC_HUM, 20'd0);           // clamps low
        queue_reading(OPC_HUM, 20'h0FFFF);       // clamps high
        queue_reading(OPC_HUM, 20'hF0000);       // upper bits ignored
        queue_reading(OPC_NONE, 20'd12345);
        queue_reading(OPC_PRESS, 20'd0);
        queue_reading(OPC_TEMP, 20'd0);
        queue_reading(OPC_PRESS, 20'hFFFFF);
        queue_reading(OPC_TEMP, 20'hFFFFF);
        queue_reading(OPC_PRESS, 20'd415148);
        wait_idle();

        // all ones: signed fields at -1, unsigned ones at their maximum
        load_coefs('1, '1, '1, '1, '1);
        queue_reading(OPC_TEMP, 20'hFFFFF);
        queue_reading(OPC_PRESS, 20'd0);
        queue_reading(OPC_HUM, 20'h0FFFF);
        wait_idle();

        // largest positive signed fields
        load_coefs({16'h7FFF, 16'h7FFF, 16'hFFFF}, {{3{16'h7FFF}}, 16'hFFFF},
                   {4{16'h7FFF}}, 16'h7FFF,
                   {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
        queue_reading(OPC_TEMP, 20'd0);
        queue_reading(OPC_PRESS, 20'hFFFFF);
        queue_reading(OPC_HUM, 20'd0);
        wait_idle();

        // random part: typical set, sender idling lightly, receiver heavily
        load_coefs(T_TYP, PL_TYP, PH_TYP, P9_TYP, H_TYP);
        queue_random(150);
        wait_idle();

        // random coefficient sets, idling swapped
        send_idle = 51;
        recv_idle = 14;
        repeat (3) begin
            load_coefs(48'({$urandom, $urandom}), {$urandom, $urandom},
                       {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
            queue_random(50);
            wait_idle();
        end

        // typical set with low-bit noise, no idling on either side
        send_idle = 0;
        recv_idle = 0;
        load_coefs(T_TYP ^ 48'($urandom_range(255)), PL_TYP ^ 64'($urandom_range(255)),
                   PH_TYP ^ 64'($urandom_range(255)), P9_TYP, H_TYP ^ 64'($urandom_range(15)));
        queue_random(150);
        wait_idle();
        repeat (50) @(posedge i_clk);

        $display("checked %0d results (%0d with zero divisor) over zero, typical,",
                 n_checked, n_zero_div);
        $display("all-ones, max-positive and random coefficient sets");
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/pthc_pkg.sv
design/pthc_serial_unit.sv
design/pth_sensor_compensation_unit.sv
test/pth_sensor_compensation_unit_tb.sv
